// ----- hdl/tsd_pkg.sv -----
// Shared types, constants and segment lookup for the temperature digit pipeline.
package tsd_pkg;

    localparam int unsigned RAW_W   = 12;
    localparam int unsigned MAG_W   = 13;
    localparam int unsigned CENTI_W = 14;
    localparam int unsigned SEG_W   = 8;
    localparam int unsigned DIGIT_W = 4;

    localparam logic [CENTI_W-1:0] CENTI_MOD = 14'd10000;
    localparam logic [CENTI_W-1:0] WEIGHT_THOUSANDS = 14'd1000;
    localparam logic [CENTI_W-1:0] WEIGHT_HUNDREDS  = 14'd100;
    localparam logic [CENTI_W-1:0] WEIGHT_TENS      = 14'd10;

    localparam int unsigned IDX_THOUSANDS = 2;
    localparam int unsigned IDX_HUNDREDS  = 1;
    localparam int unsigned IDX_TENS      = 0;

    localparam logic [SEG_W-1:0] SEG_DP   = 8'h80;
    localparam logic [SEG_W-1:0] SEG_UNIT = 8'h58;

    typedef struct packed {
        logic                          neg;
        logic [CENTI_W-1:0]            centi;
        logic [CENTI_W-1:0]            rem;
        logic [2:0][DIGIT_W-1:0]       digits;
    } tsd_item_t;

    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] code;
        unique case (d)
            4'd0:    code = 8'h3f;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5b;
            4'd3:    code = 8'h4f;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6d;
            4'd6:    code = 8'h7d;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7f;
            4'd9:    code = 8'h6f;
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

// ----- hdl/tsd_digit_stage.sv -----
// Pipeline stage that peels one decimal digit off the running remainder.
module tsd_digit_stage
    import tsd_pkg::*;
#(
    parameter logic [CENTI_W-1:0] WEIGHT    = WEIGHT_THOUSANDS,
    parameter int unsigned        DIGIT_IDX = IDX_THOUSANDS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  tsd_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output tsd_item_t out_item
);

    logic                 valid_reg;
    tsd_item_t            item_reg;
    tsd_item_t            item_next;
    logic [DIGIT_W-1:0]   digit;
    logic [CENTI_W-1:0]   sub;

    always_comb begin
        digit = '0;
        sub   = '0;
        for (int k = 1; k < 10; k++) begin
            if (in_item.rem >= CENTI_W'(k) * WEIGHT) begin
                digit = DIGIT_W'(k);
                sub   = CENTI_W'(k) * WEIGHT;
            end
        end
        item_next                   = in_item;
        item_next.rem               = in_item.rem - sub;
        item_next.digits[DIGIT_IDX] = digit;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- hdl/temperature_to_segment_digits.sv -----
// Top level: signed 1/16 degree reading to four seven-segment digits and a unit glyph.
//
// One request enters per clock unless back pressure has filled the pipeline; its
// result passes registers for magnitude, scale to rounded hundredths of a degree
// and wrap at 10000, then thousands, hundreds and tens digits one stage each, then
// segment lookup into the output register. Back pressure on m_ready holds every stage
// in place; s_ready drops only when the whole pipeline is full. The hundreds digit
// carries the decimal point, the sign is reported on m_is_negative and m_centi_degrees
// gives the unwrapped value (a reading of -2048 shows 28.00 with 12800 there).
module temperature_to_segment_digits
    import tsd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [RAW_W-1:0]   s_raw_reading,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [SEG_W-1:0]          m_thousands_segments,
    output logic [SEG_W-1:0]          m_hundreds_segments,
    output logic [SEG_W-1:0]          m_tens_segments,
    output logic [SEG_W-1:0]          m_ones_segments,
    output logic [SEG_W-1:0]          m_unit_segments,
    output logic                      m_is_negative,
    output logic [CENTI_W-1:0]        m_centi_degrees
);

    // magnitude stage
    logic               mag_valid_reg;
    logic               mag_ready;
    logic [MAG_W-1:0]   mag_reg;
    logic [MAG_W-1:0]   mag_next;
    logic               neg_reg;

    // scale stage
    logic               scl_valid_reg;
    logic               scl_ready;
    tsd_item_t          scl_item_reg;
    tsd_item_t          scl_item_next;
    logic [15:0]        scaled;
    logic [CENTI_W-1:0] centi;

    // digit stages
    logic               th_valid, th_ready, hu_valid, hu_ready, te_valid, te_ready;
    tsd_item_t          th_item, hu_item, te_item;

    // output stage
    logic               out_valid_reg;
    logic               out_ready;
    logic [SEG_W-1:0]   thousands_reg, hundreds_reg, tens_reg, ones_reg;
    logic               out_neg_reg;
    logic [CENTI_W-1:0] out_centi_reg;

    assign mag_next = s_raw_reading[RAW_W-1]
                    ? MAG_W'(~{1'b1, s_raw_reading}) + MAG_W'(1)
                    : {1'b0, s_raw_reading};

    assign s_ready = !mag_valid_reg || mag_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_valid_reg <= 1'b0;
        end else if (s_ready) begin
            mag_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            mag_reg <= mag_next;
            neg_reg <= s_raw_reading[RAW_W-1];
        end
    end

    assign scaled = 16'({mag_reg, 4'b0000}) + {mag_reg, 3'b000} + {3'b000, mag_reg}
                  + 16'd2;
    assign centi  = scaled[15:2];

    always_comb begin
        scl_item_next        = '0;
        scl_item_next.neg    = neg_reg;
        scl_item_next.centi  = centi;
        scl_item_next.rem    = (centi >= CENTI_MOD) ? centi - CENTI_MOD : centi;
    end

    assign mag_ready = !scl_valid_reg || scl_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scl_valid_reg <= 1'b0;
        end else if (mag_ready) begin
            scl_valid_reg <= mag_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mag_ready && mag_valid_reg) begin
            scl_item_reg <= scl_item_next;
        end
    end

    tsd_digit_stage #(
        .WEIGHT    (WEIGHT_THOUSANDS),
        .DIGIT_IDX (IDX_THOUSANDS)
    ) u_thousands (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scl_valid_reg),
        .in_ready  (scl_ready),
        .in_item   (scl_item_reg),
        .out_valid (th_valid),
        .out_ready (th_ready),
        .out_item  (th_item)
    );

    tsd_digit_stage #(
        .WEIGHT    (WEIGHT_HUNDREDS),
        .DIGIT_IDX (IDX_HUNDREDS)
    ) u_hundreds (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (th_valid),
        .in_ready  (th_ready),
        .in_item   (th_item),
        .out_valid (hu_valid),
        .out_ready (hu_ready),
        .out_item  (hu_item)
    );

    tsd_digit_stage #(
        .WEIGHT    (WEIGHT_TENS),
        .DIGIT_IDX (IDX_TENS)
    ) u_tens (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (hu_valid),
        .in_ready  (hu_ready),
        .in_item   (hu_item),
        .out_valid (te_valid),
        .out_ready (te_ready),
        .out_item  (te_item)
    );

    assign te_ready  = out_ready;
    assign out_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= te_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && te_valid) begin
            thousands_reg <= seg_code(te_item.digits[IDX_THOUSANDS]);
            hundreds_reg  <= seg_code(te_item.digits[IDX_HUNDREDS]) | SEG_DP;
            tens_reg      <= seg_code(te_item.digits[IDX_TENS]);
            ones_reg      <= seg_code(te_item.rem[DIGIT_W-1:0]);
            out_neg_reg   <= te_item.neg;
            out_centi_reg <= te_item.centi;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_thousands_segments = thousands_reg;
    assign m_hundreds_segments  = hundreds_reg;
    assign m_tens_segments      = tens_reg;
    assign m_ones_segments      = ones_reg;
    assign m_unit_segments      = SEG_UNIT;
    assign m_is_negative        = out_neg_reg;
    assign m_centi_degrees      = out_centi_reg;

endmodule
